/* hdl/psfb_pkg.sv */
package psfb_pkg;

  typedef enum logic [2:0] {
    KIND_CHECK = 3'd0,
    KIND_BLOCK = 3'd1,
    KIND_TICK  = 3'd2,
    KIND_CLEAR = 3'd3,
    KIND_AGE   = 3'd4
  } kind_t;

  localparam logic [1:0] VERDICT_SAFE    = 2'd0;
  localparam logic [1:0] VERDICT_NEW     = 2'd1;
  localparam logic [1:0] VERDICT_ALREADY = 2'd2;
  localparam logic [1:0] VERDICT_FULL    = 2'd3;

  localparam logic [1:0] REG_WINDOW = 2'd0;
  localparam logic [1:0] REG_LIMIT  = 2'd1;
  localparam logic [1:0] REG_GLOBAL = 2'd2;

  localparam logic [20:0] HITS_MAX    = 21'h1FFFFF;
  localparam logic [2:0]  SOUND_SCALE = 3'd5;
  localparam logic [6:0]  REMOVED_MAX = 7'd127;

  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  queue_id;
    logic [63:0] source_high;
    logic [63:0] source_low;
    logic [7:0]  multiplier;
    logic        eligible;
  } item_in_t;

  typedef struct packed {
    logic [1:0]  verdict;
    logic [20:0] applied_limit;
    logic [6:0]  removed_entries;
  } item_out_t;

  // Slot payload as stored in RAM (valid bits live in flops).
  typedef struct packed {
    logic [63:0] key_high;
    logic [63:0] key_low;
    logic [2:0]  queue;
    logic [20:0] hits;
    logic [31:0] start;
    logic        blocked;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  // Controller -> datapath.
  typedef struct packed {
    logic load;       // compute limit from the captured item
    logic scan_first; // start a walk at index 0
    logic scan_step;  // advance walk index
    logic judge;      // evaluate found / new slot, write back
    logic age_eval;   // evaluate the slot read for age-out
    logic tick;
    logic clear;
    logic done;       // emit result
  } dp_cmd_t;

  // Datapath -> controller.
  typedef struct packed {
    logic scan_last;  // entry just read is the final entry
    logic hit;        // matching slot found in the current read
  } dp_stat_t;

endpackage

/* hdl/psfb_ram.sv */
module psfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

/* hdl/psfb_ctrl.sv */
module psfb_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [2:0]         kind,
  input  psfb_pkg::dp_stat_t stat,
  output psfb_pkg::dp_cmd_t  cmd,
  output logic               busy
);
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_LOAD  = 6'b000010,
    S_SCAN  = 6'b000100,
    S_JUDGE = 6'b001000,
    S_AGE   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state, state_next;
  logic [2:0] kind_q;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
    if (start && !busy) kind_q <= kind;
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: if (start) state_next = S_LOAD;
      S_LOAD: begin
        cmd.load = 1'b1;
        if (kind_q == psfb_pkg::KIND_CHECK || kind_q == psfb_pkg::KIND_BLOCK ||
            kind_q == psfb_pkg::KIND_AGE) begin
          cmd.scan_first = 1'b1;
          state_next = (kind_q == psfb_pkg::KIND_AGE) ? S_AGE : S_SCAN;
        end else begin
          cmd.tick  = (kind_q == psfb_pkg::KIND_TICK);
          cmd.clear = (kind_q == psfb_pkg::KIND_CLEAR);
          state_next = S_DONE;
        end
      end
      // one entry per cycle; stop on a hit or at the last entry
      S_SCAN: begin
        if (stat.hit || stat.scan_last) state_next = S_JUDGE;
        else cmd.scan_step = 1'b1;
      end
      S_JUDGE: begin
        cmd.judge = 1'b1;
        state_next = S_DONE;
      end
      S_AGE: begin
        cmd.age_eval = 1'b1;
        if (stat.scan_last) state_next = S_DONE;
        else cmd.scan_step = 1'b1;
      end
      S_DONE: begin
        cmd.done = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

/* hdl/psfb_dp.sv */
module psfb_dp #(
  parameter int TABLE_ENTRIES = 64,
  parameter int QUEUE_COUNT   = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                capture,
  input  psfb_pkg::item_in_t  item_in,
  input  psfb_pkg::dp_cmd_t   cmd,
  output psfb_pkg::dp_stat_t  stat,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  output logic                result_strobe,
  output psfb_pkg::item_out_t result
);
  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam logic [IW-1:0] LAST = IW'(TABLE_ENTRIES - 1);

  logic [15:0] window_seconds;
  logic [9:0]  limit_amount;
  logic        global_mode;
  logic [31:0] seconds_now;
  logic [TABLE_ENTRIES-1:0] valid;

  psfb_pkg::item_in_t it;
  logic [20:0] limit;
  logic [IW-1:0] idx, ridx;   // idx: address being read; ridx: address of rdata
  logic rd_pend;              // a read of idx is in flight
  logic rd_ok;                // rdata corresponds to ridx
  logic [6:0] removed;
  logic       free_found;
  logic [IW-1:0] free_idx;
  logic [1:0] verdict_q;

  // matching slot held for the judge cycle (the walk reads ahead)
  psfb_pkg::slot_t cur;
  logic [IW-1:0]   cur_idx;
  logic            cur_hit;

  psfb_pkg::slot_t rdata, wdata;
  logic we;
  logic [IW-1:0] waddr;

  psfb_ram #(.WIDTH(psfb_pkg::SLOT_W), .DEPTH(TABLE_ENTRIES)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(idx), .rdata(rdata)
  );

  // config registers; a change of global mode empties the table
  always_ff @(posedge clk) begin
    if (rst) begin
      window_seconds <= 16'd2;
      limit_amount   <= 10'd10;
      global_mode    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        psfb_pkg::REG_WINDOW: window_seconds <= cfg_data;
        psfb_pkg::REG_LIMIT:  limit_amount   <= cfg_data[9:0];
        psfb_pkg::REG_GLOBAL: global_mode    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic q_ok;
  assign q_ok = ({1'b0, it.queue_id} < 4'(QUEUE_COUNT));

  // match on the entry just read
  logic match;
  assign match = rd_ok && valid[ridx] && rdata.key_high == it.source_high &&
                 rdata.key_low == it.source_low &&
                 (global_mode || rdata.queue == it.queue_id);
  assign stat.hit = match;
  assign stat.scan_last = rd_ok && (ridx == LAST);

  logic [31:0] elapsed;
  assign elapsed = seconds_now - cur.start;

  logic [31:0] age_elapsed;
  assign age_elapsed = seconds_now - rdata.start;

  logic [20:0] hits_inc;
  assign hits_inc = (cur.hits < psfb_pkg::HITS_MAX) ? cur.hits + 21'd1 : cur.hits;

  logic [12:0] base;
  assign base = (!global_mode && (it.queue_id == 3'd4 || it.queue_id == 3'd5)) ?
                13'(limit_amount) * 13'(psfb_pkg::SOUND_SCALE) : 13'(limit_amount);

  logic found;
  assign found = cur_hit;
  logic [1:0] verdict;

  // write-back for a check/block
  always_comb begin
    we = 1'b0;
    waddr = cur_idx;
    wdata = cur;
    if (cmd.judge && q_ok) begin
      if (!found) begin
        waddr = free_idx;
        wdata.key_high = it.source_high;
        wdata.key_low  = it.source_low;
        wdata.queue    = it.queue_id;
        wdata.hits     = 21'd1;
        wdata.start    = seconds_now;
        wdata.blocked  = (it.kind == psfb_pkg::KIND_BLOCK);
        we = free_found && (it.eligible || it.kind == psfb_pkg::KIND_BLOCK);
      end else if (it.kind == psfb_pkg::KIND_BLOCK) begin
        wdata.blocked = 1'b1;
        we = 1'b1;
      end else if (it.eligible && !cur.blocked) begin
        we = 1'b1;
        if (elapsed <= 32'(window_seconds)) begin
          wdata.hits = hits_inc;
          if (hits_inc > limit) wdata.blocked = 1'b1;
        end else begin
          wdata.hits = 21'd1;
          wdata.start = seconds_now;
          wdata.blocked = 1'b0;
        end
      end
    end
  end

  always_comb begin
    verdict = psfb_pkg::VERDICT_SAFE;
    if (it.kind == psfb_pkg::KIND_CHECK && q_ok && it.eligible) begin
      if (!found) verdict = free_found ? psfb_pkg::VERDICT_SAFE : psfb_pkg::VERDICT_FULL;
      else if (cur.blocked) verdict = psfb_pkg::VERDICT_ALREADY;
      else if (elapsed <= 32'(window_seconds) && hits_inc > limit)
        verdict = psfb_pkg::VERDICT_NEW;
    end
  end

  logic age_kill;
  assign age_kill = rd_ok && valid[ridx] && !rdata.blocked &&
                    age_elapsed > (32'(window_seconds) + 32'd1);

  always_ff @(posedge clk) begin
    if (capture) it <= item_in;
    if (cmd.load) limit <= 21'(base) * 21'(it.multiplier);
    if (cmd.scan_first) idx <= '0;
    else if (cmd.scan_step) idx <= idx + IW'(1);
    ridx <= idx;
    if (cmd.scan_first) cur_hit <= 1'b0;
    else if (match && !cur_hit) begin
      cur_hit <= 1'b1;
      cur     <= rdata;
      cur_idx <= ridx;
    end
    if (cmd.done) begin
      result.verdict         <= verdict_q;
      result.applied_limit   <= (it.kind == psfb_pkg::KIND_CHECK) ? limit : 21'd0;
      result.removed_entries <= (it.kind == psfb_pkg::KIND_AGE) ? removed : 7'd0;
    end else begin
      result <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) verdict_q <= psfb_pkg::VERDICT_SAFE;
    else if (cmd.judge) verdict_q <= verdict;
  end

  // control: read-valid tag, lowest free slot, valid bits, time, count
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
      rd_ok <= 1'b0;
      valid <= '0;
      seconds_now <= '0;
      result_strobe <= 1'b0;
      removed <= '0;
      free_found <= 1'b0;
      free_idx <= '0;
    end else begin
      rd_pend <= cmd.scan_first || cmd.scan_step;
      rd_ok <= rd_pend;
      result_strobe <= cmd.done;
      if (cmd.scan_first) begin
        removed <= '0;
        free_found <= 1'b0;
        free_idx <= '0;
      end
      if (rd_ok && !valid[ridx] && !free_found) begin
        free_found <= 1'b1;
        free_idx <= ridx;
      end
      if (cmd.tick) seconds_now <= seconds_now + 32'd1;
      if (cmd.clear || (cfg_we && cfg_index == psfb_pkg::REG_GLOBAL &&
                        cfg_data[0] != global_mode)) valid <= '0;
      if (we) valid[waddr] <= 1'b1;
      if (cmd.age_eval && age_kill) begin
        valid[ridx] <= 1'b0;
        if (removed < psfb_pkg::REMOVED_MAX) removed <= removed + 7'd1;
      end
    end
  end
endmodule

/* hdl/per_source_flood_blocker.sv */
// Check/block walk the table until a hit or the last entry (one RAM read per cycle);
// age-out walks the whole table; tick/clear skip the walk.
// One item at a time; busy is high until the result strobe, and the
// next item can be accepted in the strobe cycle. Config is accepted only when idle.
// Reset (rst, synchronous): table empty, seconds 0, registers at defaults.
// Results are strobed for one cycle; the receiver cannot stall.
module per_source_flood_blocker #(
  parameter int TABLE_ENTRIES = 64,
  parameter int QUEUE_COUNT   = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  psfb_pkg::item_in_t  item,
  output logic                strobe,
  output psfb_pkg::item_out_t result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);
  psfb_pkg::dp_cmd_t  cmd;
  psfb_pkg::dp_stat_t stat;

  assign cfg_ready = !busy;

  psfb_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .kind(item.kind),
    .stat(stat), .cmd(cmd), .busy(busy)
  );

  psfb_dp #(.TABLE_ENTRIES(TABLE_ENTRIES), .QUEUE_COUNT(QUEUE_COUNT)) u_dp (
    .clk(clk), .rst(rst), .capture(start && !busy), .item_in(item),
    .cmd(cmd), .stat(stat), .cfg_we(cfg_valid && cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .result_strobe(strobe), .result(result)
  );

`ifndef SYNTH
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> !busy) else $error("result strobe while busy");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("busy did not rise after accept");
  a_strobe_pulse: assert property (@(posedge clk) disable iff (rst)
    strobe |=> !strobe) else $error("strobe longer than one cycle");
`endif
endmodule
